// File: rtl/core/lru_key_value_cache_core_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms for the cache checker.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Property checked on every clock edge outside of reset
`define LCC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lru cache assertion failed");

// Property checked on every clock edge, reset included
`define LCC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lru cache assertion failed");

`endif

// File: rtl/core/lcc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, request/response types and shared helpers of the cache core.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // Number of cache slots
  localparam int ENTRIES = 16;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CAP_W  = 5;
  localparam int DATA_W = 32;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request type codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [IDX_W-1:0]  rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
  } rsp_t;

  // Lookup results handed from the match logic to the store
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free_ok;
    idx_t free_idx;
    logic lru_ok;
    idx_t lru_idx;
  } match_t;

  // Clamp a written capacity to 1 .. ENTRIES
  function automatic cnt_t eff_cap(input logic [CAP_W-1:0] v);
    cnt_t c;
    if (v == '0) begin
      c = cnt_t'(1);
    end else if (int'(v) > ENTRIES) begin
      c = cnt_t'(ENTRIES);
    end else begin
      c = cnt_t'(v);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// LRU key-value cache core
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request (get or put) is captured in an input register, looked up against
// all slots in parallel and re-ranked, and its response lands in an output
// register. Throughput is one request per cycle while the response is taken;
// the response is loaded into the output register from the input register
// through the parallel compare and rank update between the two registers. A
// stalled response holds the request side back only once the input register
// is also full. Writing the capacity register empties the cache at once; do so
// only while no request is in flight.
module lru_key_value_cache_core import lcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o
);

  logic s1_valid_q;
  req_t s1_req_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  rsp_t rsp_next;
  logic advance;
  logic process;

  // Pipeline flow control
  assign advance     = !rsp_valid_q || rsp_ready_i;
  assign process     = s1_valid_q && advance;
  assign req_ready_o = !s1_valid_q || advance;

  lcc_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .do_i        (process),
    .req_i       (s1_req_q),
    .rsp_o       (rsp_next)
  );

  // Input and response valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        s1_valid_q <= req_valid_i;
      end
      if (advance) begin
        rsp_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      s1_req_q <= req_i;
    end
    if (process) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: rtl/core/lcc_match.sv
// ----------------------------------------------------------------------------
// LRU cache match logic
// Parallel key compare plus first-free and least-recent slot search.
// ----------------------------------------------------------------------------
module lcc_match import lcc_pkg::*; (
  input  logic [ENTRIES-1:0] valid_i,
  input  word_t              keys_i [ENTRIES],
  input  rank_t              ranks_i [ENTRIES],
  input  cnt_t               occ_i,
  input  word_t              key_i,
  output match_t             match_o
);

  // Lowest index wins each search: scan downward so the last write is the lowest
  always_comb begin
    match_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (keys_i[i] == key_i)) begin
        match_o.hit     = 1'b1;
        match_o.hit_idx = idx_t'(i);
      end
      if (!valid_i[i]) begin
        match_o.free_ok  = 1'b1;
        match_o.free_idx = idx_t'(i);
      end
      // least recent valid entry has rank occupancy - 1
      if (valid_i[i] && ((cnt_t'(ranks_i[i]) + cnt_t'(1)) == occ_i)) begin
        match_o.lru_ok  = 1'b1;
        match_o.lru_idx = idx_t'(i);
      end
    end
  end

endmodule

// File: rtl/core/lcc_store.sv
// ----------------------------------------------------------------------------
// LRU cache store
// Slot arrays, recency ranks, occupancy and capacity, updated one request
// per cycle when do_i is set.
// ----------------------------------------------------------------------------
module lcc_store import lcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             do_i,
  input  req_t             req_i,
  output rsp_t             rsp_o
);

  logic [ENTRIES-1:0] valid_q, valid_d;
  word_t              key_q  [ENTRIES];
  word_t              key_d  [ENTRIES];
  word_t              data_q [ENTRIES];
  word_t              data_d [ENTRIES];
  rank_t              rank_q [ENTRIES];
  rank_t              rank_d [ENTRIES];
  cnt_t               occ_q, occ_d;
  cnt_t               cap_q, cap_d;

  match_t match;
  logic   is_put;
  logic   full;
  logic   do_touch;
  logic   do_fill;
  idx_t   tslot;
  rank_t  old_rank;

  lcc_match u_match (
    .valid_i (valid_q),
    .keys_i  (key_q),
    .ranks_i (rank_q),
    .occ_i   (occ_q),
    .key_i   (word_t'(req_i.key)),
    .match_o (match)
  );

  assign is_put   = (req_i.req_type == REQ_PUT);
  assign full     = (occ_q >= cap_q);
  assign do_touch = match.hit || (is_put && full && match.lru_ok);
  assign do_fill  = is_put && !match.hit && !full && match.free_ok;
  assign tslot    = match.hit ? match.hit_idx : match.lru_idx;
  assign old_rank = rank_q[tslot];

  // Next state of slots and ranks
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    rank_d  = rank_q;
    occ_d   = occ_q;
    cap_d   = cap_q;
    if (cfg_we_i) begin
      cap_d   = eff_cap(cfg_wdata_i);
      valid_d = '0;
      occ_d   = '0;
    end else if (do_i) begin
      if (do_touch) begin
        // entries more recent than the touched one age by one
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_q[j] && (idx_t'(j) != tslot) && (rank_q[j] < old_rank)) begin
            rank_d[j] = rank_q[j] + rank_t'(1);
          end
        end
        rank_d[tslot] = '0;
        if (is_put) begin
          key_d[tslot]  = word_t'(req_i.key);
          data_d[tslot] = word_t'(req_i.value);
        end
      end else if (do_fill) begin
        // new entry goes in front, all others age
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_q[j]) begin
            rank_d[j] = rank_q[j] + rank_t'(1);
          end
        end
        valid_d[match.free_idx] = 1'b1;
        key_d[match.free_idx]   = word_t'(req_i.key);
        data_d[match.free_idx]  = word_t'(req_i.value);
        rank_d[match.free_idx]  = '0;
        occ_d                   = occ_q + cnt_t'(1);
      end
    end
  end

  // Response of the current request
  always_comb begin
    rsp_o.hit     = match.hit;
    rsp_o.evicted = is_put && !match.hit && full && match.lru_ok;
    if (is_put) begin
      rsp_o.read_value = '0;
    end else if (match.hit) begin
      rsp_o.read_value = data_q[match.hit_idx];
    end else begin
      rsp_o.read_value = '1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= eff_cap(CAP_RESET);
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      cap_q   <= cap_d;
    end
  end

  // Slot payload, meaningful only where valid
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
    rank_q <= rank_d;
  end

endmodule

// File: rtl/core/lcc_checker.sv
// ----------------------------------------------------------------------------
// LRU cache port checker
// Port-level temporal checks, bound to the cache core.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_defines.svh"

module lcc_checker import lcc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_ready_o,
  input logic             rsp_valid_o,
  input logic             rsp_ready_i,
  input rsp_t             rsp_o
);

  // Stalled response stays put
  `LCC_ASSERT(a_rsp_hold, rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))

  // An eviction only happens on a put miss, which reads zero
  `LCC_ASSERT(a_evict_miss, rsp_valid_o && rsp_o.evicted |-> !rsp_o.hit && (rsp_o.read_value == 0))

  // A miss reads -1 on get and 0 on put
  `LCC_ASSERT(a_miss_value, rsp_valid_o && !rsp_o.hit |-> (rsp_o.read_value == 0) || (rsp_o.read_value == -1))

  // A draining output never stalls the request side
  `LCC_ASSERT_ALWAYS(a_ready_flow, rsp_ready_i |-> req_ready_o)

endmodule

bind lru_key_value_cache_core lcc_checker u_lcc_checker (.*);
